### design/ufrt_pkg.sv
// Shared types and constants for the UDP fragment reassembly tracker.
// Depends on nothing; imported by the tracker core and the top level.
`timescale 1ns / 1ps

package ufrt_pkg;

  // Frame geometry
  localparam int unsigned MAX_FRAGMENTS    = 16;
  localparam int unsigned FRAGMENT_PAYLOAD = 65491;
  localparam int unsigned MAX_FRAME_BYTES  = MAX_FRAGMENTS * FRAGMENT_PAYLOAD;

  localparam logic [15:0] HDR_BYTES = 16'd16;
  localparam logic [15:0] END_INDEX = 16'hFFFF;

  // Widths of the assembly state
  localparam int unsigned CNT_W = 5;
  localparam int unsigned LEN_W = 20;
  localparam int unsigned IDX_W = 4;

  // Verdict codes
  localparam logic [3:0] ST_ACCEPTED    = 4'd0;
  localparam logic [3:0] ST_COMPLETE    = 4'd1;
  localparam logic [3:0] ST_END         = 4'd2;
  localparam logic [3:0] ST_TRUNCATED   = 4'd3;
  localparam logic [3:0] ST_BAD_HEADER  = 4'd4;
  localparam logic [3:0] ST_NO_ASSEMBLY = 4'd5;
  localparam logic [3:0] ST_DUPLICATE   = 4'd6;
  localparam logic [3:0] ST_BAD_LENGTH  = 4'd7;
  localparam logic [3:0] ST_EMPTY       = 4'd8;

  // One parsed datagram header
  typedef struct packed {
    logic        [15:0] datagram_length;
    logic        [15:0] fragment_index;
    logic        [15:0] fragment_count;
    logic        [31:0] frame_length;
    logic signed [63:0] timestamp;
  } ufrt_in_t;

  // One verdict
  typedef struct packed {
    logic        [3:0]  status;
    logic        [19:0] write_offset;
    logic        [15:0] write_length;
    logic        [19:0] done_length;
    logic signed [63:0] done_timestamp;
  } ufrt_out_t;

endpackage

### design/ufrt_tracker.sv
// Assembly state and verdict logic of the fragment reassembly tracker.
// Depends on ufrt_pkg; the verdict is combinational, state commits on advance.
`timescale 1ns / 1ps

module ufrt_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  ufrt_pkg::ufrt_in_t item,
  output ufrt_pkg::ufrt_out_t verdict
);
  import ufrt_pkg::*;

  // Assembly state
  logic        [CNT_W-1:0] asm_count_r,     asm_count_nxt;
  logic        [LEN_W-1:0] asm_length_r,    asm_length_nxt;
  logic signed [63:0]      asm_timestamp_r, asm_timestamp_nxt;
  logic        [15:0]      received_mask_r, received_mask_nxt;
  logic        [LEN_W-1:0] bytes_gathered_r, bytes_gathered_nxt;

  // Decoded header and working values
  logic        [15:0]      payload;
  logic        [CNT_W-1:0] cnt5;
  logic        [IDX_W-1:0] idx4;
  logic        [LEN_W-1:0] flen20;
  logic        [LEN_W-1:0] cnt_limit;
  logic                    is_zero;
  logic                    params_differ;
  logic                    replace;
  logic                    take;
  logic                    complete;
  logic        [CNT_W-1:0] eff_count;
  logic        [LEN_W-1:0] eff_length;
  logic signed [63:0]      eff_ts;
  logic        [15:0]      eff_mask;
  logic        [LEN_W-1:0] eff_bytes;
  logic        [LEN_W-1:0] offset;
  logic        [LEN_W-1:0] expected;
  logic        [LEN_W-1:0] gathered_sum;
  logic        [15:0]      mask_new;
  logic        [15:0]      full;

  // Evaluate one header against the current assembly
  always_comb begin
    payload       = item.datagram_length - HDR_BYTES;
    cnt5          = item.fragment_count[CNT_W-1:0];
    idx4          = item.fragment_index[IDX_W-1:0];
    flen20        = item.frame_length[LEN_W-1:0];
    cnt_limit     = LEN_W'(cnt5) * LEN_W'(FRAGMENT_PAYLOAD);
    is_zero       = (item.fragment_index == 16'd0);
    params_differ = (asm_count_r != cnt5) || (asm_length_r != flen20) ||
                    (asm_timestamp_r != item.timestamp);

    eff_count  = (is_zero && params_differ) ? cnt5 : asm_count_r;
    eff_length = (is_zero && params_differ) ? flen20 : asm_length_r;
    eff_ts     = (is_zero && params_differ) ? item.timestamp : asm_timestamp_r;
    eff_mask   = (is_zero && params_differ) ? 16'd0 : received_mask_r;
    eff_bytes  = (is_zero && params_differ) ? '0 : bytes_gathered_r;

    offset       = LEN_W'(idx4) * LEN_W'(FRAGMENT_PAYLOAD);
    expected     = ((CNT_W'(idx4) + CNT_W'(1)) == eff_count) ? (eff_length - offset)
                                                             : LEN_W'(FRAGMENT_PAYLOAD);
    gathered_sum = eff_bytes + expected;
    mask_new     = eff_mask | (16'd1 << idx4);
    full         = 16'((17'd1 << eff_count) - 17'd1);

    replace  = 1'b0;
    take     = 1'b0;
    complete = 1'b0;
    verdict  = '0;

    if (item.datagram_length < HDR_BYTES) begin
      verdict.status = ST_TRUNCATED;
    end else if (item.fragment_index == END_INDEX && item.fragment_count == 16'd0 &&
                 item.frame_length == 32'd0) begin
      verdict.status = ST_END;
    end else if (item.fragment_count == 16'd0 ||
                 item.fragment_count > 16'(MAX_FRAGMENTS) ||
                 item.fragment_index >= item.fragment_count ||
                 item.frame_length > 32'(MAX_FRAME_BYTES) ||
                 flen20 > cnt_limit) begin
      verdict.status = ST_BAD_HEADER;
    end else if (payload == 16'd0) begin
      verdict.status = ST_BAD_LENGTH;
    end else begin
      replace = is_zero && params_differ;
      if (is_zero && eff_length == '0) begin
        verdict.status = ST_EMPTY;
      end else if (eff_count == '0 || eff_length == '0 || eff_count != cnt5 ||
                   eff_ts != item.timestamp || eff_length != flen20) begin
        verdict.status = ST_NO_ASSEMBLY;
      end else if (eff_mask[idx4]) begin
        verdict.status = ST_DUPLICATE;
      end else if (offset >= eff_length) begin
        verdict.status = ST_BAD_LENGTH;
      end else if (expected == '0 || LEN_W'(payload) != expected) begin
        verdict.status = ST_BAD_LENGTH;
      end else begin
        take                 = 1'b1;
        complete             = ((mask_new & full) == full) && (gathered_sum == eff_length);
        verdict.write_offset = offset;
        verdict.write_length = expected[15:0];
        if (complete) begin
          verdict.status         = ST_COMPLETE;
          verdict.done_length    = eff_length;
          verdict.done_timestamp = eff_ts;
        end else begin
          verdict.status = ST_ACCEPTED;
        end
      end
    end
  end

  // Next assembly state
  always_comb begin
    asm_count_nxt      = asm_count_r;
    asm_length_nxt     = asm_length_r;
    asm_timestamp_nxt  = asm_timestamp_r;
    received_mask_nxt  = received_mask_r;
    bytes_gathered_nxt = bytes_gathered_r;
    if (advance) begin
      if (replace) begin
        asm_count_nxt      = cnt5;
        asm_length_nxt     = flen20;
        asm_timestamp_nxt  = item.timestamp;
        received_mask_nxt  = 16'd0;
        bytes_gathered_nxt = '0;
      end
      if (take) begin
        received_mask_nxt  = mask_new;
        bytes_gathered_nxt = gathered_sum;
        if (complete) begin
          asm_count_nxt      = '0;
          asm_length_nxt     = '0;
          bytes_gathered_nxt = '0;
        end
      end
    end
  end

  // Hold the assembly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_count_r      <= '0;
      asm_length_r     <= '0;
      asm_timestamp_r  <= '0;
      received_mask_r  <= '0;
      bytes_gathered_r <= '0;
    end else begin
      asm_count_r      <= asm_count_nxt;
      asm_length_r     <= asm_length_nxt;
      asm_timestamp_r  <= asm_timestamp_nxt;
      received_mask_r  <= received_mask_nxt;
      bytes_gathered_r <= bytes_gathered_nxt;
    end
  end

endmodule

### design/udp_fragment_reassembly_tracker_top.sv
// Throughput: one header per cycle while the skid register is empty; the assembly
// registers settle each header in the cycle it is taken, and a two-entry output buffer
// (output plus skid) decouples the sides. Reset (rst_n low, synchronous) clears the
// assembly and empties the buffer. Verdicts are registered into this buffer.
// Top level of the UDP fragment reassembly tracker; depends on ufrt_pkg, ufrt_tracker.
`timescale 1ns / 1ps

module udp_fragment_reassembly_tracker_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufrt_pkg::ufrt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ufrt_pkg::ufrt_out_t out_data
);
  import ufrt_pkg::*;

  logic      in_take;
  ufrt_out_t verdict;

  logic      out_valid_r,  out_valid_nxt;
  ufrt_out_t out_data_r,   out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  ufrt_out_t skid_data_r,  skid_data_nxt;

  // Take a transaction whenever the skid stage is free
  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;

  ufrt_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_take),
    .item    (in_data),
    .verdict (verdict)
  );

  // Advance the output buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && !out_stall) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (in_take) begin
      if (!out_valid_r || !out_stall) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = verdict;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = verdict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/tb_top.sv
// Self-checking bench for the UDP fragment reassembly tracker: directed and random headers.
// Depends on ufrt_pkg and udp_fragment_reassembly_tracker_top; predicts every verdict in-line.
`timescale 1ns / 1ps

module tb_top;
  import ufrt_pkg::*;

  localparam int unsigned PAY       = FRAGMENT_PAYLOAD;
  localparam int unsigned N_HEADERS = 625;
  localparam int unsigned HOLD_AT   = 150;
  localparam int unsigned HOLD_LEN  = 400;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ufrt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ufrt_out_t out_data;

  udp_fragment_reassembly_tracker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Headers waiting to be sent and verdicts waiting to arrive
  ufrt_in_t  pending_headers[$];
  ufrt_out_t expected_verdicts[$];

  // Shadow copy of the assembly registers
  logic [4:0]  asm_cnt = '0;
  logic [19:0] asm_len = '0;
  logic [63:0] asm_ts = '0;
  logic [15:0] asm_mask = '0;
  logic [19:0] asm_gathered = '0;

  bit          in_took = 1'b0;
  int unsigned errors = 0;
  int unsigned headers_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned status_count[16];

  // Work out the verdict for one header and advance the shadow assembly
  function automatic ufrt_out_t track_datagram(input ufrt_in_t d);
    ufrt_out_t   v;
    logic [15:0] payload;
    logic [15:0] frag_bit;
    logic [31:0] offset;
    logic [31:0] expected;
    logic [31:0] full;
    v = '0;
    if (d.datagram_length < HDR_BYTES) begin
      v.status = ST_TRUNCATED;
      return v;
    end
    if (d.fragment_index == END_INDEX && d.fragment_count == 16'd0 &&
        d.frame_length == 32'd0) begin
      v.status = ST_END;
      return v;
    end
    if (d.fragment_count < 16'd1 || d.fragment_count > 16'(MAX_FRAGMENTS) ||
        d.fragment_index >= d.fragment_count ||
        64'(d.frame_length) > 64'(MAX_FRAME_BYTES) ||
        64'(d.frame_length) > 64'(d.fragment_count) * 64'(PAY)) begin
      v.status = ST_BAD_HEADER;
      return v;
    end
    payload = d.datagram_length - HDR_BYTES;
    if (payload == 16'd0) begin
      v.status = ST_BAD_LENGTH;
      return v;
    end
    // Fragment zero opens a fresh assembly when its parameters differ
    if (d.fragment_index == 16'd0) begin
      if (32'(asm_cnt) != 32'(d.fragment_count) || 32'(asm_len) != d.frame_length ||
          asm_ts != d.timestamp) begin
        asm_cnt      = d.fragment_count[4:0];
        asm_len      = d.frame_length[19:0];
        asm_ts       = d.timestamp;
        asm_mask     = '0;
        asm_gathered = '0;
      end
      if (asm_len == 20'd0) begin
        v.status = ST_EMPTY;
        return v;
      end
    end
    if (asm_cnt == 5'd0 || asm_len == 20'd0 ||
        32'(asm_cnt) != 32'(d.fragment_count) || asm_ts != d.timestamp ||
        32'(asm_len) != d.frame_length) begin
      v.status = ST_NO_ASSEMBLY;
      return v;
    end
    frag_bit = 16'd1 << d.fragment_index[3:0];
    if ((asm_mask & frag_bit) != 16'd0) begin
      v.status = ST_DUPLICATE;
      return v;
    end
    offset = 32'(d.fragment_index) * 32'(PAY);
    if (offset >= 32'(asm_len)) begin
      v.status = ST_BAD_LENGTH;
      return v;
    end
    expected = (32'(d.fragment_index) + 32'd1 == 32'(asm_cnt)) ? (32'(asm_len) - offset)
                                                               : 32'(PAY);
    if (expected == 32'd0 || 32'(payload) != expected) begin
      v.status = ST_BAD_LENGTH;
      return v;
    end
    asm_gathered = asm_gathered + expected[19:0];
    asm_mask     = asm_mask | frag_bit;
    v.write_offset = offset[19:0];
    v.write_length = expected[15:0];
    full = (32'd1 << asm_cnt) - 32'd1;
    if (({16'd0, asm_mask} & full) == full && asm_gathered == asm_len) begin
      v.status         = ST_COMPLETE;
      v.done_length    = asm_len;
      v.done_timestamp = asm_ts;
      asm_cnt      = '0;
      asm_len      = '0;
      asm_gathered = '0;
    end else begin
      v.status = ST_ACCEPTED;
    end
    return v;
  endfunction

  // Compare one verdict against the oldest prediction
  task automatic check_verdict(input ufrt_out_t got);
    ufrt_out_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected verdict: status %0d", got.status);
      errors++;
      return;
    end
    want = expected_verdicts.pop_front();
    status_count[want.status]++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.write_offset !== want.write_offset) begin
      $error("write_offset: expected %0d, actual %0d", want.write_offset, got.write_offset);
      errors++;
    end
    if (got.write_length !== want.write_length) begin
      $error("write_length: expected %0d, actual %0d", want.write_length, got.write_length);
      errors++;
    end
    if (got.done_length !== want.done_length) begin
      $error("done_length: expected %0d, actual %0d", want.done_length, got.done_length);
      errors++;
    end
    if (got.done_timestamp !== want.done_timestamp) begin
      $error("done_timestamp: expected %h, actual %h", want.done_timestamp, got.done_timestamp);
      errors++;
    end
  endtask

  task automatic add_header(input logic [15:0] dlen, idx, cnt, input logic [31:0] flen,
                            input logic [63:0] ts);
    ufrt_in_t h;
    h.datagram_length = dlen;
    h.fragment_index  = idx;
    h.fragment_count  = cnt;
    h.frame_length    = flen;
    h.timestamp       = ts;
    pending_headers.push_back(h);
  endtask

  // One frame as fragments, mostly well-formed, with occasional faults
  task automatic queue_frame();
    int unsigned cnt;
    int unsigned flen;
    int unsigned order[16];
    int unsigned k;
    int unsigned j;
    int unsigned tmp;
    int unsigned idx;
    int unsigned pay;
    int unsigned r;
    logic [63:0] ts;
    r = $urandom_range(0, 9);
    if (r < 6) cnt = $urandom_range(1, 3);
    else if (r < 9) cnt = $urandom_range(4, 8);
    else cnt = $urandom_range(9, 16);
    if ($urandom_range(0, 7) == 0) flen = $urandom_range(0, cnt * PAY);
    else flen = (cnt - 1) * PAY + $urandom_range(1, PAY);
    if ($urandom_range(0, 3) == 0) ts = 64'($urandom_range(0, 3));
    else ts = {$urandom(), $urandom()};
    for (k = 0; k < cnt; k++) order[k] = k;
    // Keep fragment zero first most of the time, shuffle the rest
    for (k = ($urandom_range(0, 4) == 0) ? 0 : 1; k + 1 < cnt; k++) begin
      j = $urandom_range(k, cnt - 1);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < cnt; k++) begin
      idx = order[k];
      if (flen <= idx * PAY) pay = $urandom_range(1, 100);
      else if (idx == cnt - 1) pay = flen - idx * PAY;
      else pay = PAY;
      case ($urandom_range(0, 11))
        0: add_header(16'(pay + 17), 16'(idx), 16'(cnt), flen, ts);
        1: add_header(16'(pay + 16), 16'(idx), 16'(cnt), flen,
                      ts ^ (64'd1 << $urandom_range(0, 63)));
        2: begin
          add_header(16'(pay + 16), 16'(idx), 16'(cnt), flen, ts);
          add_header(16'(pay + 16), 16'(idx), 16'(cnt), flen, ts);
        end
        3: ;
        4: add_header(16'($urandom_range(0, 15)), 16'(idx), 16'(cnt), flen, ts);
        default: add_header(16'(pay + 16), 16'(idx), 16'(cnt), flen, ts);
      endcase
    end
  endtask

  // Unstructured headers: full-range fields, short datagrams, end markers, in-range headers
  task automatic queue_noise();
    int unsigned cnt;
    case ($urandom_range(0, 3))
      0: add_header(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(),
                    {$urandom(), $urandom()});
      1: add_header(16'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()),
                    $urandom(), {$urandom(), $urandom()});
      2: add_header(16'($urandom_range(16, 65535)), END_INDEX, 16'd0, 32'd0,
                    {$urandom(), $urandom()});
      default: begin
        cnt = $urandom_range(1, MAX_FRAGMENTS);
        add_header(16'($urandom_range(16, 65535)), 16'($urandom_range(0, cnt - 1)),
                   16'(cnt), $urandom_range(0, cnt * PAY), 64'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // Predict on every accepted header, check every accepted verdict
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        expected_verdicts.push_back(track_datagram(in_data));
        headers_taken++;
      end
      if (out_valid && !out_stall) begin
        check_verdict(out_data);
        verdicts_seen++;
      end
    end
  end

  // Sender: bursts of headers separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled transaction
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_headers.size() > 0) begin
      in_data  <= pending_headers.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern of its own plus one long hold-off
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && verdicts_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_stall <= ~out_stall;
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Truncated datagrams and end markers
    add_header(16'd0, 16'd0, 16'd1, 32'd10, 64'd0);
    add_header(16'd15, 16'd0, 16'd1, 32'd10, 64'd0);
    add_header(16'd16, END_INDEX, 16'd0, 32'd0, 64'd0);
    add_header(16'hFFFF, END_INDEX, 16'd0, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    // Bad headers: zero count, too many fragments, index past count, oversize frames
    add_header(16'd100, 16'd0, 16'd0, 32'd50, 64'd0);
    add_header(16'd100, 16'd0, 16'd17, 32'd50, 64'd0);
    add_header(16'd100, 16'd2, 16'd2, 32'd50, 64'd0);
    add_header(16'd100, 16'd0, 16'd16, MAX_FRAME_BYTES + 1, 64'd0);
    add_header(16'd100, 16'd0, 16'd1, PAY + 1, 64'd0);
    add_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // Header with no payload, fragment before any assembly, empty frame
    add_header(16'd16, 16'd0, 16'd1, 32'd10, 64'd0);
    add_header(16'd116, 16'd1, 16'd2, 32'd100, 64'd0);
    add_header(16'd20, 16'd0, 16'd1, 32'd0, 64'd7);
    // Single full fragment completes at once
    add_header(16'(PAY + 16), 16'd0, 16'd1, PAY, 64'h8000_0000_0000_0000);
    // Fragment one before any assembly (twice), fragment zero of wrong size, then fragment zero
    add_header(16'd21, 16'd1, 16'd2, PAY + 5, 64'h7FFF_FFFF_FFFF_FFFF);
    add_header(16'd21, 16'd1, 16'd2, PAY + 5, 64'h7FFF_FFFF_FFFF_FFFF);
    add_header(16'd100, 16'd0, 16'd2, PAY + 5, 64'h7FFF_FFFF_FFFF_FFFF);
    add_header(16'(PAY + 16), 16'd0, 16'd2, PAY + 5, 64'h7FFF_FFFF_FFFF_FFFF);
    // Mismatched timestamp and count against an open assembly
    add_header(16'(PAY + 16), 16'd0, 16'd3, 3 * PAY, 64'd5);
    add_header(16'(PAY + 16), 16'd1, 16'd3, 3 * PAY, 64'd6);
    add_header(16'(PAY + 16), 16'd2, 16'd4, 3 * PAY, 64'd5);
    add_header(16'(PAY + 16), 16'd1, 16'd3, 3 * PAY, 64'd5);
    add_header(16'(PAY + 16), 16'd2, 16'd3, 3 * PAY, 64'd5);
    // Offset past a short frame
    add_header(16'(PAY + 16), 16'd0, 16'd3, 32'd10, 64'd0);
    add_header(16'(PAY + 16), 16'd1, 16'd3, 32'd10, 64'd0);
    // Random part: mostly whole frames, some noise
    while (pending_headers.size() < N_HEADERS) begin
      if ($urandom_range(0, 5) == 0) queue_noise();
      else queue_frame();
    end

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    while (pending_headers.size() != 0 || in_valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d headers, checked %0d verdicts: %0d complete, %0d accepted,",
             headers_taken, verdicts_seen, status_count[ST_COMPLETE],
             status_count[ST_ACCEPTED]);
    $display("  %0d duplicate, %0d no assembly, %0d bad length, %0d bad header, %0d empty.",
             status_count[ST_DUPLICATE], status_count[ST_NO_ASSEMBLY],
             status_count[ST_BAD_LENGTH], status_count[ST_BAD_HEADER],
             status_count[ST_EMPTY]);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
design/ufrt_pkg.sv
design/ufrt_tracker.sv
design/udp_fragment_reassembly_tracker_top.sv
sim/tb_top.sv
